// File: design/tnfs_pkg.sv
// ----------------------------------------------------------------------------
// tnfs_pkg
// Shared types and constants of the table NCO frequency shifter: sample
// request layouts, phasor layout and fixed-point widths.
// ----------------------------------------------------------------------------
package tnfs_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int COEF_BITS   = 16;
  localparam int FRAC_BITS   = 15;
  localparam int OFFSET_BITS = 15;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] in_re;
    logic signed [SAMPLE_BITS-1:0] in_im;
    logic                          last_in;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] out_re;
    logic signed [SAMPLE_BITS-1:0] out_im;
    logic                          last_out;
  } out_item_t;

  typedef struct packed {
    logic signed [COEF_BITS-1:0] cos_q15;
    logic signed [COEF_BITS-1:0] sin_q15;
  } phasor_t;

endpackage

// File: design/tnfs_rom.sv
// ----------------------------------------------------------------------------
// tnfs_rom
// Cosine / sine lookup ROM, Q1.15, one entry per phase step of a full turn.
// Contents are built at elaboration with a quadrant-reduced Taylor series;
// read data is registered.
// ----------------------------------------------------------------------------
module tnfs_rom import tnfs_pkg::*; #(
  parameter int TABLE_SIZE = 16384,
  parameter int IDX_W      = 14
) (
  input  logic             clk_i,
  input  logic             rd_en_i,
  input  logic [IDX_W-1:0] addr_i,
  output phasor_t          data_o
);

  localparam longint unsigned PI_Q30  = 64'd3373259426;
  localparam longint          Q30_ONE = 64'd1073741824;
  localparam longint unsigned DIV_S [1:10] = '{6, 20, 42, 72, 110, 156, 210, 272, 342, 420};
  localparam longint unsigned DIV_C [1:10] = '{2, 12, 30, 56, 90, 132, 182, 240, 306, 380};

  function automatic logic signed [COEF_BITS-1:0] q15_f(input longint v);
    longint w;
    longint r;
    w = v;
    if (w < 0) w = 0;
    if (w > Q30_ONE) w = Q30_ONE;
    r = (w + 64'd16384) >>> FRAC_BITS;
    if (r > 32767) r = 32767;
    return r[COEF_BITS-1:0];
  endfunction

  function automatic phasor_t entry_f(input int unsigned i);
    longint unsigned t;
    longint unsigned r;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned ts;
    longint unsigned tc;
    longint          s;
    longint          c;
    logic [1:0]      quad;
    logic signed [COEF_BITS-1:0] cs;
    logic signed [COEF_BITS-1:0] sn;
    phasor_t         e;
    t    = (longint'(i) << 32) / TABLE_SIZE;
    quad = t[31:30];
    r    = t & 64'h3FFF_FFFF;
    // angle in radians, Q30
    x    = (r * (2 * PI_Q30)) >> 32;
    x2   = (x * x) >> 30;
    ts   = x;
    tc   = Q30_ONE;
    s    = longint'(x);
    c    = Q30_ONE;
    for (int k = 1; k <= 10; k++) begin
      ts = ((ts * x2) >> 30) / DIV_S[k];
      tc = ((tc * x2) >> 30) / DIV_C[k];
      if (k % 2 == 1) begin
        s = s - longint'(ts);
        c = c - longint'(tc);
      end else begin
        s = s + longint'(ts);
        c = c + longint'(tc);
      end
    end
    cs = q15_f(c);
    sn = q15_f(s);
    case (quad)
      2'd0: begin
        e.cos_q15 = cs;
        e.sin_q15 = sn;
      end
      2'd1: begin
        e.cos_q15 = -sn;
        e.sin_q15 = cs;
      end
      2'd2: begin
        e.cos_q15 = -cs;
        e.sin_q15 = -sn;
      end
      default: begin
        e.cos_q15 = sn;
        e.sin_q15 = -cs;
      end
    endcase
    return e;
  endfunction

  phasor_t rom_w [TABLE_SIZE];
  phasor_t data_q;

  for (genvar gi = 0; gi < TABLE_SIZE; gi++) begin : g_entry
    localparam phasor_t ENTRY = entry_f(gi);
    assign rom_w[gi] = ENTRY;
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      data_q <= rom_w[addr_i];
    end
  end

  assign data_o = data_q;

endmodule

// File: design/table_nco_frequency_shifter.sv
// ----------------------------------------------------------------------------
// table_nco_frequency_shifter
// Complex frequency shifter: each sample is multiplied by a unit phasor read
// from a cosine / sine ROM, and the phase index steps back by the offset
// register after every sample.
//
//   channel  signals                          width  direction
//   in       in_valid_i in_stall_o in_data_i  33     into block
//   out      out_valid_o out_stall_i out_data_o 33   out of block
//   cfg      cfg_we_i cfg_data_i               15     into block
//
// one sample per cycle sustained while the output is not stalled; the result
// is registered at the ROM read and again at the multiply / round stage
// reset clears the offset, the phase index and both valid flags; the ROM
// needs no clearing pass
// a stalled result holds in the output register while the middle stage
// can still take one more request
// ----------------------------------------------------------------------------
module table_nco_frequency_shifter import tnfs_pkg::*; #(
  parameter int TABLE_SIZE = 16384
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  in_item_t                      in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output out_item_t                     out_data_o,
  input  logic                          cfg_we_i,
  input  logic signed [OFFSET_BITS-1:0] cfg_data_i
);

  localparam int IDX_W   = $clog2(TABLE_SIZE);
  localparam int PW      = ((IDX_W > OFFSET_BITS) ? IDX_W : OFFSET_BITS) + 2;
  localparam int OFS_LIM = (1 << (OFFSET_BITS - 1)) - 1;
  localparam int OFS_MAX = (TABLE_SIZE - 1 < OFS_LIM) ? (TABLE_SIZE - 1) : OFS_LIM;
  localparam logic signed [PW-1:0] OFS_HI = PW'(OFS_MAX);
  localparam logic signed [PW-1:0] OFS_LO = PW'(-OFS_MAX);
  localparam logic signed [PW-1:0] TS_S   = PW'(TABLE_SIZE);

  localparam int ACC_W = SAMPLE_BITS + COEF_BITS + 1;
  localparam int QW    = ACC_W - FRAC_BITS;
  localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1 << (FRAC_BITS - 1));
  localparam logic signed [QW-1:0]    SAT_HI   = QW'((1 << (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [QW-1:0]    SAT_LO   = QW'(-(1 << (SAMPLE_BITS - 1)));

  // round half up, then saturate to the sample range
  function automatic logic signed [SAMPLE_BITS-1:0] round_sat(
    input logic signed [ACC_W-1:0] acc
  );
    logic signed [ACC_W-1:0] v;
    logic signed [QW-1:0]    q;
    logic signed [QW-1:0]    r;
    v = acc + RND_HALF;
    q = v[ACC_W-1:FRAC_BITS];
    if (q > SAT_HI) begin
      r = SAT_HI;
    end else if (q < SAT_LO) begin
      r = SAT_LO;
    end else begin
      r = q;
    end
    return r[SAMPLE_BITS-1:0];
  endfunction

  // ---------------- offset register
  logic signed [OFFSET_BITS-1:0] ofs_q;
  logic signed [PW-1:0]          ofs_ext;
  logic signed [PW-1:0]          ofs_sat;

  assign ofs_ext = PW'(cfg_data_i);

  always_comb begin
    if (ofs_ext > OFS_HI) begin
      ofs_sat = OFS_HI;
    end else if (ofs_ext < OFS_LO) begin
      ofs_sat = OFS_LO;
    end else begin
      ofs_sat = ofs_ext;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ofs_q <= '0;
    end else if (cfg_we_i) begin
      ofs_q <= ofs_sat[OFFSET_BITS-1:0];
    end
  end

  // ---------------- handshake
  logic      s1_valid_q;
  logic      s1_valid_d;
  logic      out_valid_q;
  logic      out_valid_d;
  logic      s1_load;
  logic      s2_load;
  logic      s2_ready;
  in_item_t  s1_item_q;
  out_item_t out_item_q;
  out_item_t out_item_d;

  assign s2_ready   = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !s2_ready;
  assign s1_load    = in_valid_i && !in_stall_o;
  assign s2_load    = s1_valid_q && s2_ready;

  always_comb begin
    if (s1_load) begin
      s1_valid_d = 1'b1;
    end else if (s2_load) begin
      s1_valid_d = 1'b0;
    end else begin
      s1_valid_d = s1_valid_q;
    end
    if (s2_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // ---------------- phase index
  logic [IDX_W-1:0]     phase_q;
  logic [IDX_W-1:0]     phase_d;
  logic signed [PW-1:0] diff;
  logic signed [PW-1:0] wrapped;

  assign diff = signed'({{(PW - IDX_W){1'b0}}, phase_q}) - PW'(ofs_q);

  always_comb begin
    if (diff < 0) begin
      wrapped = diff + TS_S;
    end else if (diff >= TS_S) begin
      wrapped = diff - TS_S;
    end else begin
      wrapped = diff;
    end
    phase_d = wrapped[IDX_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
    end else if (s1_load) begin
      phase_q <= phase_d;
    end
  end

  // ---------------- stage 1: sample register and ROM read
  phasor_t phasor;

  tnfs_rom #(
    .TABLE_SIZE(TABLE_SIZE),
    .IDX_W     (IDX_W)
  ) u_rom (
    .clk_i  (clk_i),
    .rd_en_i(s1_load),
    .addr_i (phase_q),
    .data_o (phasor)
  );

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_item_q <= in_data_i;
    end
  end

  // ---------------- stage 2: complex multiply, round, saturate
  logic signed [SAMPLE_BITS+COEF_BITS-1:0] p_rc;
  logic signed [SAMPLE_BITS+COEF_BITS-1:0] p_is;
  logic signed [SAMPLE_BITS+COEF_BITS-1:0] p_rs;
  logic signed [SAMPLE_BITS+COEF_BITS-1:0] p_ic;
  logic signed [ACC_W-1:0]                 acc_re;
  logic signed [ACC_W-1:0]                 acc_im;

  assign p_rc   = s1_item_q.in_re * phasor.cos_q15;
  assign p_is   = s1_item_q.in_im * phasor.sin_q15;
  assign p_rs   = s1_item_q.in_re * phasor.sin_q15;
  assign p_ic   = s1_item_q.in_im * phasor.cos_q15;
  assign acc_re = ACC_W'(p_rc) - ACC_W'(p_is);
  assign acc_im = ACC_W'(p_rs) + ACC_W'(p_ic);

  always_comb begin
    out_item_d.out_re   = round_sat(acc_re);
    out_item_d.out_im   = round_sat(acc_im);
    out_item_d.last_out = s1_item_q.last_in;
  end

  always_ff @(posedge clk_i) begin
    if (s2_load) begin
      out_item_q <= out_item_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_item_q;

  // ---------------- assertions
  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(phase_q) < TABLE_SIZE)
    else $error("phase index left the table range");

  a_phase_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_load |=> $stable(phase_q))
    else $error("phase index moved without an input request");

  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s2_ready |=> s1_valid_q)
    else $error("middle stage lost a request while the output was stalled");

  a_ofs_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    PW'(ofs_q) <= OFS_HI && PW'(ofs_q) >= OFS_LO)
    else $error("offset register outside its saturated range");

endmodule

// File: verif/table_nco_frequency_shifter_tb.sv
// ----------------------------------------------------------------------------
// table_nco_frequency_shifter_tb
// Self-checking bench for the table NCO frequency shifter. A scoreboard class
// rebuilds the cosine / sine table from the same fixed-point series, tracks
// the phase index and the offset register, and predicts every shifted sample.
// Directed corners come first, then random samples over several offsets,
// with random idling on both channels and a long output hold-off.
// ----------------------------------------------------------------------------
module table_nco_frequency_shifter_tb;
  import tnfs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_SIZE = 16384;
  localparam int LONG_HOLD = 80;
  localparam int TIMEOUT_NS = 400_000;

  class shift_scoreboard;
    localparam longint unsigned PI_Q30 = 64'd3373259426;
    localparam longint Q30_ONE = 64'sd1073741824;

    int cos_rom[TABLE_SIZE];
    int sin_rom[TABLE_SIZE];
    int phase;
    int offset;
    out_item_t shifted_q[$];
    int unsigned errors;

    function new();
      longint unsigned t, r, x, x2, ts, tc;
      longint s, c;
      int quad, cs, sn;
      for (int i = 0; i < TABLE_SIZE; i++) begin
        t = (longint'(i) << 32) / TABLE_SIZE;
        quad = int'((t >> 30) & 3);
        r = t & 64'h3FFF_FFFF;
        x = (r * (2 * PI_Q30)) >> 32;
        x2 = (x * x) >> 30;
        ts = x;
        tc = Q30_ONE;
        s = longint'(x);
        c = Q30_ONE;
        // taylor series for sine and cosine of the reduced angle
        for (int k = 1; k <= 10; k++) begin
          ts = ((ts * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
          tc = ((tc * x2) >> 30) / longint'((2 * k - 1) * (2 * k));
          if (k % 2 == 1) begin
            s -= longint'(ts);
            c -= longint'(tc);
          end else begin
            s += longint'(ts);
            c += longint'(tc);
          end
        end
        cs = q30_to_q15(c);
        sn = q30_to_q15(s);
        case (quad)
          0: begin
            cos_rom[i] = cs;
            sin_rom[i] = sn;
          end
          1: begin
            cos_rom[i] = -sn;
            sin_rom[i] = cs;
          end
          2: begin
            cos_rom[i] = -cs;
            sin_rom[i] = -sn;
          end
          default: begin
            cos_rom[i] = sn;
            sin_rom[i] = -cs;
          end
        endcase
      end
      phase = 0;
      offset = 0;
      errors = 0;
    endfunction

    static function int q30_to_q15(longint v);
      longint q;
      if (v < 0) v = 0;
      if (v > Q30_ONE) v = Q30_ONE;
      q = (v + 16384) >>> 15;
      if (q > 32767) q = 32767;
      return int'(q);
    endfunction

    // round half up from q.15, then clamp to the sample range
    static function logic signed [SAMPLE_BITS-1:0] round_sat(longint acc);
      longint q;
      longint hi;
      hi = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
      q = (acc + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
      if (q > hi) q = hi;
      if (q < -hi - 1) q = -hi - 1;
      return q[SAMPLE_BITS-1:0];
    endfunction

    function void set_offset(logic signed [OFFSET_BITS-1:0] v);
      offset = int'(v);
      // the most negative code clamps so one wrap correction is enough
      if (offset > TABLE_SIZE - 1) offset = TABLE_SIZE - 1;
      if (offset < -(TABLE_SIZE - 1)) offset = -(TABLE_SIZE - 1);
    endfunction

    function void note_sample(in_item_t smp);
      longint re, im, c, s;
      int p;
      out_item_t e;
      re = longint'(smp.in_re);
      im = longint'(smp.in_im);
      c = cos_rom[phase];
      s = sin_rom[phase];
      e.out_re = round_sat(re * c - im * s);
      e.out_im = round_sat(re * s + im * c);
      e.last_out = smp.last_in;
      shifted_q.push_back(e);
      p = phase - offset;
      if (p < 0) p += TABLE_SIZE;
      if (p >= TABLE_SIZE) p -= TABLE_SIZE;
      phase = p;
    endfunction

    function void check_result(out_item_t got);
      out_item_t e;
      if (shifted_q.size() == 0) begin
        $display("%0t: unexpected result re %0d im %0d last %0b",
                 $time, got.out_re, got.out_im, got.last_out);
        errors++;
        return;
      end
      e = shifted_q.pop_front();
      if (got.out_re !== e.out_re) begin
        $display("%0t: out_re expected %0d actual %0d", $time, e.out_re, got.out_re);
        errors++;
      end
      if (got.out_im !== e.out_im) begin
        $display("%0t: out_im expected %0d actual %0d", $time, e.out_im, got.out_im);
        errors++;
      end
      if (got.last_out !== e.last_out) begin
        $display("%0t: last_out expected %0b actual %0b", $time, e.last_out,
                 got.last_out);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return shifted_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_item_t in_data;
  logic out_valid;
  logic out_stall;
  out_item_t out_data;
  logic cfg_we;
  logic signed [OFFSET_BITS-1:0] cfg_data;

  shift_scoreboard sb;
  bit tx_idle_on;
  bit rx_idle_on;
  bit long_hold;

  table_nco_frequency_shifter #(
    .TABLE_SIZE(TABLE_SIZE)
  ) u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_data_i (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic in_item_t make_sample(int re, int im, bit last);
    in_item_t smp;
    smp.in_re = re[SAMPLE_BITS-1:0];
    smp.in_im = im[SAMPLE_BITS-1:0];
    smp.last_in = last;
    return smp;
  endfunction

  // full-scale values show up often so rounding and saturation get hit
  function automatic int rand_level();
    case ($urandom_range(0, 7))
      0: return 32767;
      1: return -32768;
      default: return int'($signed(16'($urandom)));
    endcase
  endfunction

  function automatic in_item_t rand_sample();
    return make_sample(rand_level(), rand_level(), $urandom_range(0, 7) == 0);
  endfunction

  task automatic send_sample(input in_item_t smp);
    in_valid <= 1'b1;
    in_data <= smp;
    do @(posedge clk); while (in_stall);
    sb.note_sample(smp);
  endtask

  task automatic idle_in(input int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // block must be empty before the offset changes
  task automatic write_offset(input logic signed [OFFSET_BITS-1:0] v);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_offset(v);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  // output side back-pressure
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold = 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    int corner[4];
    logic signed [OFFSET_BITS-1:0] off;
    corner = '{32767, -32768, 1, -1};
    sb = new();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    long_hold = 1'b0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_we <= 1'b0;
    cfg_data <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero offset after reset: phasor stays at angle zero
    send_sample(make_sample(32767, -32768, 1'b0));
    send_sample(make_sample(-32768, 32767, 1'b1));
    send_sample(make_sample(0, 0, 1'b0));
    send_sample(make_sample(-1, -1, 1'b1));
    send_sample(make_sample(1, 1, 1'b0));

    // eighth-turn steps walk every quadrant and the diagonals
    write_offset(-15'sd2048);
    for (int k = 0; k < 16; k++) begin
      send_sample(make_sample(corner[k % 4], corner[(k / 4) % 4], k % 3 == 0));
    end

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: off = 15'sd16383;
        1: off = -15'sd16384;
        2: off = 15'sd1;
        3: off = -15'sd1;
        default: off = 15'($urandom);
      endcase
      tx_idle_on = (ph != 7);
      rx_idle_on = (ph != 7);
      write_offset(off);
      if (ph == 4) long_hold = 1'b1;
      for (int n = 0; n < 50; n++) begin
        if (tx_idle_on && ph != 4 && $urandom_range(0, 3) == 0) begin
          idle_in($urandom_range(1, 6));
        end
        send_sample(rand_sample());
      end
    end

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.errors == 0) begin
      $display("[table_nco_frequency_shifter] OK");
    end else begin
      $display("[table_nco_frequency_shifter] ERROR");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("[table_nco_frequency_shifter] ERROR");
    $finish;
  end

endmodule
